[design/modexp_pkg.sv]
// modexp_pkg: shared widths, register indexes and control types
// for the modular exponentiation unit; no dependencies
`timescale 1ns / 1ps

package modexp_pkg;

  // operand width of modulus, exponent and values
  localparam int DATA_WIDTH = 63;
  // bit counter width, counts DATA_WIDTH-1 down to 0
  localparam int CNT_W = $clog2(DATA_WIDTH);
  // configuration index width, leaves room for unused indexes
  localparam int IDX_W = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MODULUS  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_EXPONENT = IDX_W'(1);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_FINISH
  } state_e;

  // status of a serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

[design/modexp_mul.sv]
// modexp_mul: bit-serial modular multiplier, a*b mod m, msb of b first
// each bit of b takes a double step, then a conditional add step; uses modexp_pkg
`timescale 1ns / 1ps

module modexp_mul import modexp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  input  logic [DATA_WIDTH-1:0] m_i,
  output mul_stat_t             stat_o,
  output logic [DATA_WIDTH-1:0] prod_o
);

  logic                  busy_q, busy_d;
  logic                  phase_q, phase_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;

  logic [DATA_WIDTH:0]   addend;
  logic [DATA_WIDTH:0]   sum;
  logic [DATA_WIDTH:0]   diff;

  // one adder: doubles in phase 0, adds a in phase 1 when the bit is set
  always_comb begin
    if (!phase_q) begin
      addend = {1'b0, acc_q};
    end else if (b_q[DATA_WIDTH-1]) begin
      addend = {1'b0, a_q};
    end else begin
      addend = '0;
    end
    sum  = {1'b0, acc_q} + addend;
    diff = sum - {1'b0, m_i};
  end

  // step control
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      cnt_d   = CNT_W'(DATA_WIDTH - 1);
      a_d     = a_i;
      b_d     = b_i;
      acc_d   = '0;
    end else if (busy_q) begin
      // sum stays below 2m, one subtract reduces it
      acc_d   = (sum >= {1'b0, m_i}) ? diff[DATA_WIDTH-1:0] : sum[DATA_WIDTH-1:0];
      phase_d = !phase_q;
      if (phase_q) begin
        b_d = {b_q[DATA_WIDTH-2:0], 1'b0};
        if (cnt_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

[design/modular_exponentiation_unit.sv]
// modular_exponentiation_unit: value_in ^ exponent mod modulus, right-to-left
// square-and-multiply over two bit-serial multipliers; uses modexp_pkg, modexp_mul
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+-------------------------------
// input     | in_valid_i/in_stall_o | value_in_i
// output    | out_valid_o/out_stall_i | value_out_o
// config    | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// a request is accepted, then its input value is reduced bit-serially modulo
// modulus, then for each exponent bit up to the highest set one the square and
// the multiply run side by side in the two serial multipliers, then the output
// register is loaded. modulus below two gives 0 right after the accept.
// reset sets modulus 2 and exponent 1. in_stall_o is high while a request is
// at work; a finished result waits in the output register while out_stall_i.

module modular_exponentiation_unit import modexp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] value_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_WIDTH-1:0] value_out_o,
  input  logic                  cfg_we_i,
  input  logic [IDX_W-1:0]      cfg_idx_i,
  input  logic [DATA_WIDTH-1:0] cfg_data_i
);

  state_e                state_q, state_d;
  logic [DATA_WIDTH-1:0] mod_q, exp_q;
  logic [DATA_WIDTH-1:0] x_q, x_d;
  logic [DATA_WIDTH-1:0] sq_q, sq_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] e_q, e_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_q, out_d;
  logic                  mul_start;
  mul_stat_t             stat_m, stat_s;
  logic [DATA_WIDTH-1:0] prod_m, prod_s;
  logic [DATA_WIDTH:0]   rem_t, rem_diff;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= DATA_WIDTH'(2);
      exp_q <= DATA_WIDTH'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODULUS:  mod_q <= cfg_data_i;
        REG_EXPONENT: exp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // multiply unit: acc * sq
  modexp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (acc_q),
    .b_i     (sq_q),
    .m_i     (mod_q),
    .stat_o  (stat_m),
    .prod_o  (prod_m)
  );

  // square unit: sq * sq
  modexp_mul u_sqr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (sq_q),
    .b_i     (sq_q),
    .m_i     (mod_q),
    .stat_o  (stat_s),
    .prod_o  (prod_s)
  );

  // restoring remainder step, one input bit a cycle
  always_comb begin
    rem_t    = {sq_q, x_q[DATA_WIDTH-1]};
    rem_diff = rem_t - {1'b0, mod_q};
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    sq_d        = sq_q;
    acc_d       = acc_q;
    e_d         = e_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mul_start   = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d   = value_in_i;
          sq_d  = '0;
          e_d   = exp_q;
          cnt_d = CNT_W'(DATA_WIDTH - 1);
          if (mod_q < DATA_WIDTH'(2)) begin
            acc_d   = '0;
            state_d = ST_FINISH;
          end else begin
            acc_d   = DATA_WIDTH'(1);
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        sq_d = (rem_t >= {1'b0, mod_q}) ? rem_diff[DATA_WIDTH-1:0]
                                        : rem_t[DATA_WIDTH-1:0];
        x_d  = {x_q[DATA_WIDTH-2:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = (e_q == '0) ? ST_FINISH : ST_MUL_START;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_MUL_START: begin
        mul_start = 1'b1;
        state_d   = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (stat_m.done && stat_s.done) begin
          if (e_q[0]) begin
            acc_d = prod_m;
          end
          sq_d    = prod_s;
          e_d     = {1'b0, e_q[DATA_WIDTH-1:1]};
          state_d = (e_q[DATA_WIDTH-1:1] == '0) ? ST_FINISH : ST_MUL_START;
        end
      end
      ST_FINISH: begin
        // load the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    sq_q  <= sq_d;
    acc_q <= acc_d;
    e_q   <= e_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_q;

endmodule

[design/modexp_checker.sv]
// modexp_checker: port-level assertions for the modular exponentiation unit
// bound to modular_exponentiation_unit; uses modexp_pkg
`timescale 1ns / 1ps

module modexp_checker import modexp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DATA_WIDTH-1:0] value_out_o
);

  // a result waiting on stall stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_out_o))
    else $error("result changed while stalled");

  // an accepted request then blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after a request");

  // a new result only comes from a request at work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request at work");

endmodule

bind modular_exponentiation_unit modexp_checker u_modexp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_out_o (value_out_o)
);
